/* rtl/ctq_pkg.sv */
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared types and codes of the coalescing task queue.
// ----------------------------------------------------------------------------
package ctq_pkg;

  // command codes of an input request
  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_DEQ  = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  // result status codes
  localparam logic [2:0] ST_QUEUED     = 3'd0;
  localparam logic [2:0] ST_COALESCED  = 3'd1;
  localparam logic [2:0] ST_DATA_FULL  = 3'd2;
  localparam logic [2:0] ST_CTRL_FULL  = 3'd3;
  localparam logic [2:0] ST_REFUSED    = 3'd4;
  localparam logic [2:0] ST_POPPED     = 3'd5;
  localparam logic [2:0] ST_EMPTY      = 3'd6;

  // entry flag bit positions
  localparam int FLAG_COAL_BIT = 0;
  localparam int FLAG_CTRL_BIT = 1;
  localparam int FLAG_DISC_BIT = 2;
  localparam int FLAG_W        = 3;
  localparam int KEY_W         = 64;
  localparam int GEN_W         = 64;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINAL,
    S_POP
  } state_t;

endpackage

/* rtl/coalescing_task_queue_core.sv */
// ----------------------------------------------------------------------------
// coalescing_task_queue_core
// Ordered task-handle queue with purge, coalescing and per-class limits.
// ----------------------------------------------------------------------------
// One request is handled at a time. Entries live in a circular RAM of
// DATA_DEPTH+CONTROL_DEPTH slots. An enqueue walks the queued entries once,
// one RAM read per cycle, compacting out purged entries and looking for a
// coalescing match, then inserts or merges in the final state. A dequeue
// takes the head entry from the registered RAM read in the pop state; stop,
// refusal and empty dequeue are answered straight from the idle state.
// The next request is taken once the result register is free or being drained.
module coalescing_task_queue_core #(
  parameter int DATA_DEPTH    = 16,
  parameter int CONTROL_DEPTH = 4,
  parameter int HANDLE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_key,
  input  logic        in_is_coalescing,
  input  logic        in_is_control,
  input  logic        in_is_discardable,
  input  logic [63:0] in_event_generation,
  input  logic        in_purge_all_discardable,
  input  logic        in_purge_one_generation,
  input  logic [63:0] in_obsolete_generation,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_popped_payload,
  output logic        out_popped_control,
  output logic [4:0]  out_pending_count,
  output logic [31:0] out_rejected_data_total,
  output logic [31:0] out_rejected_control_total,
  output logic [31:0] out_coalesced_total,
  output logic [31:0] out_discarded_total,
  output logic        out_finished
);

  localparam int SLOTS = DATA_DEPTH + CONTROL_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int DCW   = $clog2(DATA_DEPTH + 1);
  localparam int CCW   = $clog2(CONTROL_DEPTH + 1);
  localparam int FW    = ctq_pkg::FLAG_W;
  localparam int HLO   = FW;
  localparam int GLO   = HLO + HANDLE_BITS;
  localparam int KLO   = GLO + ctq_pkg::GEN_W;
  localparam int EW    = KLO + ctq_pkg::KEY_W;

  // circular slot address: base plus offset, wrapped once
  function automatic logic [AW-1:0] slot_addr(logic [AW-1:0] base, logic [CW-1:0] ofs);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(ofs);
    if (s >= (CW+1)'(SLOTS)) s = s - (CW+1)'(SLOTS);
    return AW'(s);
  endfunction

  ctq_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  occ_r, occ_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [CCW-1:0] ccnt_r, ccnt_nxt;
  logic [31:0]    rej_d_r, rej_d_nxt, rej_c_r, rej_c_nxt;
  logic [31:0]    coal_r, coal_nxt, disc_r, disc_nxt;
  logic           stopped_r, stopped_nxt;
  logic [4:0]     limit_r;

  // scan bookkeeping
  logic [CW-1:0]  rd_i_r, rd_i_nxt, p_r, p_nxt, keep_r, keep_nxt;
  logic           pv_r, pv_nxt, found_r, found_nxt;
  logic [AW-1:0]  match_addr_r, match_addr_nxt;
  logic [EW-1:0]  match_word_r, match_word_nxt;

  // latched request
  logic [63:0]            key_r, gen_r, obs_r;
  logic                   coal_in_r, ctrl_in_r, disc_in_r, pall_r, pgen_r;
  logic [HANDLE_BITS-1:0] handle_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_pop_r, out_rd_r, out_rc_r, out_co_r, out_di_r;
  logic        out_pctl_r, out_fin_r;
  logic [4:0]  out_pend_r;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  ctq_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic                   can_out, accept, prod;
  logic [2:0]             prod_status;
  logic [31:0]            prod_pop;
  logic                   prod_pctl;
  logic [HANDLE_BITS-1:0] in_handle;
  logic                   rd_issue, scan_done, want_coal;
  logic [FW-1:0]          rflags;
  logic                   purge_hit, match_hit;
  logic [DCW-1:0]         eff_lim;

  assign can_out   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ctq_pkg::S_IDLE) && can_out;
  assign accept    = in_valid && in_ready;
  assign in_handle = HANDLE_BITS'(in_payload);
  assign rd_issue  = (state_r == ctq_pkg::S_SCAN) && (rd_i_r < occ_r);
  assign scan_done = (state_r == ctq_pkg::S_SCAN) && !rd_issue && !pv_r;
  assign want_coal = coal_in_r && !ctrl_in_r;
  assign rflags    = ram_rdata[FW-1:0];
  // scan walks the queue; otherwise the head is read for a dequeue
  assign ram_raddr = (state_r == ctq_pkg::S_SCAN) ? slot_addr(head_r, rd_i_r) : head_r;

  assign purge_hit = (pall_r || pgen_r) && !rflags[ctq_pkg::FLAG_CTRL_BIT]
                     && rflags[ctq_pkg::FLAG_DISC_BIT]
                     && (!pgen_r || ram_rdata[KLO-1:GLO] == obs_r);
  assign match_hit = want_coal && !found_r && !rflags[ctq_pkg::FLAG_CTRL_BIT]
                     && rflags[ctq_pkg::FLAG_COAL_BIT] && ram_rdata[EW-1:KLO] == key_r;

  // effective data limit: zero acts as one, saturate at DATA_DEPTH
  always_comb begin
    if (32'(limit_r) >= DATA_DEPTH) eff_lim = DCW'(DATA_DEPTH);
    else if (limit_r == 5'd0)        eff_lim = DCW'(1);
    else                             eff_lim = DCW'(limit_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctq_pkg::S_IDLE: begin
        if (accept && in_kind == ctq_pkg::KIND_ENQ && in_handle != '0 && !stopped_r)
          state_nxt = ctq_pkg::S_SCAN;
        else if (accept && in_kind == ctq_pkg::KIND_DEQ && occ_r != '0)
          state_nxt = ctq_pkg::S_POP;
      end
      ctq_pkg::S_SCAN:  if (scan_done) state_nxt = ctq_pkg::S_FINAL;
      ctq_pkg::S_FINAL: if (can_out) state_nxt = ctq_pkg::S_IDLE;
      ctq_pkg::S_POP:   if (can_out) state_nxt = ctq_pkg::S_IDLE;
      default:          state_nxt = ctq_pkg::S_IDLE;
    endcase
  end

  // datapath and result generation
  always_comb begin
    head_nxt = head_r;  occ_nxt = occ_r;  dcnt_nxt = dcnt_r;  ccnt_nxt = ccnt_r;
    rej_d_nxt = rej_d_r;  rej_c_nxt = rej_c_r;  coal_nxt = coal_r;  disc_nxt = disc_r;
    stopped_nxt = stopped_r;
    rd_i_nxt = rd_i_r;  p_nxt = p_r;  keep_nxt = keep_r;  pv_nxt = 1'b0;
    found_nxt = found_r;  match_addr_nxt = match_addr_r;  match_word_nxt = match_word_r;
    ram_we = 1'b0;  ram_waddr = slot_addr(head_r, keep_r);  ram_wdata = ram_rdata;
    prod = 1'b0;  prod_status = ctq_pkg::ST_REFUSED;  prod_pop = '0;  prod_pctl = 1'b0;
    unique case (state_r)
      ctq_pkg::S_IDLE: begin
        rd_i_nxt = '0;  p_nxt = '0;  keep_nxt = '0;  found_nxt = 1'b0;
        if (accept) begin
          unique case (in_kind)
            ctq_pkg::KIND_ENQ: begin
              if (in_handle == '0 || stopped_r) prod = 1'b1;
            end
            ctq_pkg::KIND_DEQ: begin
              if (occ_r == '0) begin
                prod = 1'b1;
                prod_status = ctq_pkg::ST_EMPTY;
              end
            end
            ctq_pkg::KIND_STOP: begin
              prod = 1'b1;
              stopped_nxt = 1'b1;
            end
            default: prod = 1'b1;
          endcase
        end
      end
      ctq_pkg::S_SCAN: begin
        if (rd_issue) begin
          rd_i_nxt = rd_i_r + CW'(1);
          pv_nxt = 1'b1;
        end
        if (pv_r) begin
          p_nxt = p_r + CW'(1);
          if (purge_hit) begin
            disc_nxt = disc_r + 32'd1;
            dcnt_nxt = dcnt_r - DCW'(1);
          end else begin
            if (keep_r != p_r) ram_we = 1'b1;
            if (match_hit) begin
              found_nxt = 1'b1;
              match_addr_nxt = slot_addr(head_r, keep_r);
              match_word_nxt = ram_rdata;
            end
            keep_nxt = keep_r + CW'(1);
          end
        end
        if (scan_done) occ_nxt = keep_r;
      end
      ctq_pkg::S_FINAL: begin
        ram_waddr = slot_addr(head_r, occ_r);
        ram_wdata = {key_r, gen_r, handle_r, disc_in_r, ctrl_in_r, coal_in_r};
        if (can_out) begin
          prod = 1'b1;
          if (ctrl_in_r) begin
            if (ccnt_r >= CCW'(CONTROL_DEPTH)) begin
              rej_c_nxt = rej_c_r + 32'd1;
              prod_status = ctq_pkg::ST_CTRL_FULL;
            end else if (occ_r >= CW'(SLOTS)) begin
              prod_status = ctq_pkg::ST_CTRL_FULL;
            end else begin
              ram_we = 1'b1;
              occ_nxt = occ_r + CW'(1);
              ccnt_nxt = ccnt_r + CCW'(1);
              prod_status = ctq_pkg::ST_QUEUED;
            end
          end else if (want_coal && found_r) begin
            ram_we = 1'b1;
            ram_waddr = match_addr_r;
            ram_wdata = {match_word_r[EW-1:GLO], handle_r, match_word_r[FW-1:0]};
            coal_nxt = coal_r + 32'd1;
            prod_status = ctq_pkg::ST_COALESCED;
          end else if (dcnt_r >= eff_lim) begin
            rej_d_nxt = rej_d_r + 32'd1;
            prod_status = ctq_pkg::ST_DATA_FULL;
          end else if (occ_r >= CW'(SLOTS)) begin
            prod_status = ctq_pkg::ST_DATA_FULL;
          end else begin
            ram_we = 1'b1;
            occ_nxt = occ_r + CW'(1);
            dcnt_nxt = dcnt_r + DCW'(1);
            prod_status = ctq_pkg::ST_QUEUED;
          end
        end
      end
      ctq_pkg::S_POP: begin
        if (can_out) begin
          prod = 1'b1;
          prod_status = ctq_pkg::ST_POPPED;
          prod_pop = 32'(ram_rdata[GLO-1:HLO]);
          prod_pctl = rflags[ctq_pkg::FLAG_CTRL_BIT];
          if (rflags[ctq_pkg::FLAG_CTRL_BIT]) ccnt_nxt = ccnt_r - CCW'(1);
          else                                 dcnt_nxt = dcnt_r - DCW'(1);
          head_nxt = slot_addr(head_r, CW'(1));
          occ_nxt = occ_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctq_pkg::S_IDLE;
      head_r <= '0;  occ_r <= '0;  dcnt_r <= '0;  ccnt_r <= '0;
      rej_d_r <= '0;  rej_c_r <= '0;  coal_r <= '0;  disc_r <= '0;
      stopped_r <= 1'b0;  limit_r <= 5'd16;
      rd_i_r <= '0;  p_r <= '0;  keep_r <= '0;  pv_r <= 1'b0;  found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;  occ_r <= occ_nxt;  dcnt_r <= dcnt_nxt;  ccnt_r <= ccnt_nxt;
      rej_d_r <= rej_d_nxt;  rej_c_r <= rej_c_nxt;  coal_r <= coal_nxt;  disc_r <= disc_nxt;
      stopped_r <= stopped_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      rd_i_r <= rd_i_nxt;  p_r <= p_nxt;  keep_r <= keep_nxt;  pv_r <= pv_nxt;
      found_r <= found_nxt;
      if (prod)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    match_addr_r <= match_addr_nxt;
    match_word_r <= match_word_nxt;
    if (accept) begin
      key_r <= in_key;  gen_r <= in_event_generation;  obs_r <= in_obsolete_generation;
      coal_in_r <= in_is_coalescing;  ctrl_in_r <= in_is_control;
      disc_in_r <= in_is_discardable;  pall_r <= in_purge_all_discardable;
      pgen_r <= in_purge_one_generation;  handle_r <= in_handle;
    end
    if (prod) begin
      out_status_r <= prod_status;
      out_pop_r <= prod_pop;
      out_pctl_r <= prod_pctl;
      out_pend_r <= 5'(occ_nxt);
      out_rd_r <= rej_d_nxt;  out_rc_r <= rej_c_nxt;
      out_co_r <= coal_nxt;  out_di_r <= disc_nxt;
      out_fin_r <= stopped_nxt && occ_nxt == '0;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_status                 = out_status_r;
  assign out_popped_payload         = out_pop_r;
  assign out_popped_control         = out_pctl_r;
  assign out_pending_count          = out_pend_r;
  assign out_rejected_data_total    = out_rd_r;
  assign out_rejected_control_total = out_rc_r;
  assign out_coalesced_total        = out_co_r;
  assign out_discarded_total        = out_di_r;
  assign out_finished               = out_fin_r;

`ifndef SYNTHESIS
  // occupancy is always the sum of both class counts in the idle state
  a_occ_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ctq_pkg::S_IDLE |-> occ_r == CW'(dcnt_r) + CW'(ccnt_r))
    else $error("occupancy does not match class counts");

  // compaction never writes ahead of the entry being processed
  a_keep_le_proc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ctq_pkg::S_SCAN |-> keep_r <= p_r)
    else $error("compaction write index passed read index");

  // control count stays within its limit
  a_ctrl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ccnt_r <= CCW'(CONTROL_DEPTH))
    else $error("control count above limit");
`endif

endmodule

/* rtl/ctq_ram.sv */
// ----------------------------------------------------------------------------
// ctq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed queue requests with random idling on both
// channels and checks every response against an in-bench queue predictor.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_DEPTH    = 16;
  localparam int CONTROL_DEPTH = 4;
  localparam int SLOTS         = DATA_DEPTH + CONTROL_DEPTH;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic        coal;
    logic        ctrl;
    logic        disc;
    logic [63:0] gen;
    logic        purge_all;
    logic        purge_gen;
    logic [63:0] obsolete;
    logic [31:0] handle;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pop_handle;
    logic        pop_ctrl;
    logic [4:0]  pending;
    logic [31:0] rej_data;
    logic [31:0] rej_ctrl;
    logic [31:0] coalesced;
    logic [31:0] discarded;
    logic        finished;
  } response_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] gen;
    logic [31:0] handle;
    logic        coal;
    logic        ctrl;
    logic        disc;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_acc = 1'b0;
  request_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  response_t out_rsp;

  request_t  pending_reqs[$];
  response_t expected_rsps[$];
  entry_t    model_q[$];
  int        model_data, model_ctrl;
  logic [31:0] cnt_rej_data, cnt_rej_ctrl, cnt_coal, cnt_disc;
  logic      model_stopped;
  logic [4:0] model_limit;
  int        errors = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  int        in_gap = 0, out_gap = 0;

  always #10 clk = ~clk;

  coalescing_task_queue_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_req.kind), .in_key(in_req.key), .in_is_coalescing(in_req.coal),
    .in_is_control(in_req.ctrl), .in_is_discardable(in_req.disc),
    .in_event_generation(in_req.gen), .in_purge_all_discardable(in_req.purge_all),
    .in_purge_one_generation(in_req.purge_gen),
    .in_obsolete_generation(in_req.obsolete), .in_payload(in_req.handle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_rsp.status), .out_popped_payload(out_rsp.pop_handle),
    .out_popped_control(out_rsp.pop_ctrl), .out_pending_count(out_rsp.pending),
    .out_rejected_data_total(out_rsp.rej_data),
    .out_rejected_control_total(out_rsp.rej_ctrl),
    .out_coalesced_total(out_rsp.coalesced),
    .out_discarded_total(out_rsp.discarded), .out_finished(out_rsp.finished)
  );

  // Enqueue decision: refuse, purge, then control bound or coalesce or data bound
  function automatic logic [2:0] enqueue_status(request_t r);
    int lim;
    int i;
    entry_t ent;
    if (r.handle == '0 || model_stopped) return ctq_pkg::ST_REFUSED;
    if (r.purge_all || r.purge_gen) begin
      i = 0;
      while (i < model_q.size()) begin
        if (!model_q[i].ctrl && model_q[i].disc &&
            (!r.purge_gen || model_q[i].gen == r.obsolete)) begin
          model_q.delete(i);
          model_data--;
          cnt_disc++;
        end else begin
          i++;
        end
      end
    end
    if (r.ctrl) begin
      if (model_ctrl >= CONTROL_DEPTH) begin
        cnt_rej_ctrl++;
        return ctq_pkg::ST_CTRL_FULL;
      end
    end else begin
      if (r.coal) begin
        foreach (model_q[j]) begin
          if (!model_q[j].ctrl && model_q[j].coal && model_q[j].key == r.key) begin
            model_q[j].handle = r.handle;
            cnt_coal++;
            return ctq_pkg::ST_COALESCED;
          end
        end
      end
      lim = (model_limit == 0) ? 1 : int'(model_limit);
      if (lim > DATA_DEPTH) lim = DATA_DEPTH;
      if (model_data >= lim) begin
        cnt_rej_data++;
        return ctq_pkg::ST_DATA_FULL;
      end
    end
    if (model_q.size() >= SLOTS)
      return r.ctrl ? ctq_pkg::ST_CTRL_FULL : ctq_pkg::ST_DATA_FULL;
    ent = '{r.key, r.gen, r.handle, r.coal, r.ctrl, r.disc};
    model_q.insert(model_q.size(), ent);
    if (r.ctrl) model_ctrl++;
    else model_data++;
    return ctq_pkg::ST_QUEUED;
  endfunction

  function automatic response_t predict_response(request_t r);
    response_t p;
    p = '0;
    p.status = ctq_pkg::ST_REFUSED;
    case (r.kind)
      ctq_pkg::KIND_ENQ: p.status = enqueue_status(r);
      ctq_pkg::KIND_DEQ: begin
        if (model_q.size() == 0) begin
          p.status = ctq_pkg::ST_EMPTY;
        end else begin
          p.pop_handle = model_q[0].handle;
          p.pop_ctrl = model_q[0].ctrl;
          if (model_q[0].ctrl) model_ctrl--;
          else model_data--;
          model_q.delete(0);
          p.status = ctq_pkg::ST_POPPED;
        end
      end
      ctq_pkg::KIND_STOP: model_stopped = 1'b1;
      default: ;
    endcase
    p.pending = 5'(model_q.size());
    p.rej_data = cnt_rej_data;
    p.rej_ctrl = cnt_rej_ctrl;
    p.coalesced = cnt_coal;
    p.discarded = cnt_disc;
    p.finished = model_stopped && model_q.size() == 0;
    return p;
  endfunction

  // Request acceptance seen at the rising edge
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && in_ready;
  end

  // Driver: falling-edge updates, valid held until accepted
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        expected_rsps.insert(expected_rsps.size(), predict_response(in_req));
      end
      if (!in_valid || in_acc) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_req <= pending_reqs[0];
          pending_reqs.delete(0);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    response_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response status=%0d", out_rsp.status);
        errors++;
      end else begin
        e = expected_rsps[0];
        expected_rsps.delete(0);
        if (out_rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_rsp.status); errors++;
        end
        if (out_rsp.pop_handle !== e.pop_handle) begin
          $error("popped_payload exp %0h got %0h", e.pop_handle, out_rsp.pop_handle);
          errors++;
        end
        if (out_rsp.pop_ctrl !== e.pop_ctrl) begin
          $error("popped_control exp %0d got %0d", e.pop_ctrl, out_rsp.pop_ctrl);
          errors++;
        end
        if (out_rsp.pending !== e.pending) begin
          $error("pending_count exp %0d got %0d", e.pending, out_rsp.pending); errors++;
        end
        if (out_rsp.rej_data !== e.rej_data) begin
          $error("rejected_data_total exp %0d got %0d", e.rej_data, out_rsp.rej_data);
          errors++;
        end
        if (out_rsp.rej_ctrl !== e.rej_ctrl) begin
          $error("rejected_control_total exp %0d got %0d", e.rej_ctrl, out_rsp.rej_ctrl);
          errors++;
        end
        if (out_rsp.coalesced !== e.coalesced) begin
          $error("coalesced_total exp %0d got %0d", e.coalesced, out_rsp.coalesced);
          errors++;
        end
        if (out_rsp.discarded !== e.discarded) begin
          $error("discarded_total exp %0d got %0d", e.discarded, out_rsp.discarded);
          errors++;
        end
        if (out_rsp.finished !== e.finished) begin
          $error("finished exp %0d got %0d", e.finished, out_rsp.finished); errors++;
        end
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_request(request_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  function automatic request_t make_enqueue(logic [63:0] key, logic [31:0] handle,
                                            logic coal, logic ctrl, logic disc,
                                            logic [63:0] gen, logic pa, logic pg,
                                            logic [63:0] obs);
    request_t r;
    r = '{ctq_pkg::KIND_ENQ, key, coal, ctrl, disc, gen, pa, pg, obs, handle};
    return r;
  endfunction

  function automatic request_t make_command(logic [1:0] kind);
    request_t r;
    r = '0;
    r.kind = kind;
    r.key = {$urandom, $urandom};
    r.handle = $urandom;
    return r;
  endfunction

  // Dequeues, some invalid commands and mostly well-formed enqueues from small key and generation pools
  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return make_command(ctq_pkg::KIND_DEQ);
    if (pick == 40) return make_command(2'd3);
    r.kind = ctq_pkg::KIND_ENQ;
    if ($urandom_range(0, 9) == 0) begin
      r.key = {$urandom, $urandom};
      r.gen = {$urandom, $urandom};
      r.obsolete = {$urandom, $urandom};
    end else begin
      r.key = 64'($urandom_range(0, 5));
      r.gen = 64'($urandom_range(0, 3));
      r.obsolete = 64'($urandom_range(0, 3));
    end
    r.coal = 1'($urandom_range(0, 1));
    r.ctrl = ($urandom_range(0, 4) == 0);
    r.disc = 1'($urandom_range(0, 1));
    r.purge_all = ($urandom_range(0, 9) == 0);
    r.purge_gen = ($urandom_range(0, 9) == 0);
    r.handle = ($urandom_range(0, 29) == 0) ? 32'd0 : $urandom;
    if (r.handle == 0 && $urandom_range(0, 1) == 1) r.handle = 32'hFFFF_FFFF;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    model_limit = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic reset_model();
    model_q.delete();
    model_data = 0;
    model_ctrl = 0;
    cnt_rej_data = 0;
    cnt_rej_ctrl = 0;
    cnt_coal = 0;
    cnt_disc = 0;
    model_stopped = 1'b0;
    model_limit = 5'd16;
  endtask

  initial begin
    logic [4:0] limits[6];
    limits = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd8};
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, extremes, coalescing, control bound, purges
    add_request(make_command(ctq_pkg::KIND_DEQ));
    add_request(make_enqueue('0, 32'd0, 1'b1, 1'b0, 1'b1, '0, 1'b1, 1'b0, '0));
    add_request(make_enqueue('1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, '1, 1'b0, 1'b0, '0));
    add_request(make_enqueue('1, 32'd7, 1'b1, 1'b0, 1'b0, 64'd5, 1'b0, 1'b0, '0));
    add_request(make_enqueue('1, 32'd9, 1'b1, 1'b1, 1'b1, 64'd5, 1'b0, 1'b0, '0));
    for (int i = 0; i < 4; i++)
      add_request(make_enqueue(64'd3, 32'd20 + i, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0, '0));
    add_request(make_enqueue(64'd4, 32'd30, 1'b0, 1'b0, 1'b1, 64'd2, 1'b0, 1'b0, '0));
    add_request(make_enqueue(64'd5, 32'd31, 1'b0, 1'b0, 1'b1, 64'd3, 1'b0, 1'b1, 64'd2));
    add_request(make_enqueue(64'd6, 32'd32, 1'b0, 1'b1, 1'b0, '0, 1'b1, 1'b1, '1));
    add_request(make_enqueue(64'd7, 32'd33, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0, '0));
    for (int i = 0; i < 6; i++) add_request(make_command(ctq_pkg::KIND_DEQ));
    add_request(make_command(2'd3));
    wait_drained();

    // Tight limit, fill past it
    write_limit(5'd1);
    for (int i = 0; i < 3; i++)
      add_request(make_enqueue(64'd10 + i, 32'd40 + i, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0,
                               '0));
    wait_drained();

    // Random phases across limit settings
    foreach (limits[k]) begin
      write_limit(limits[k]);
      for (int i = 0; i < 75; i++) add_request(random_request());
      wait_drained();
    end

    // Stopped queue refuses enqueues but still pops
    add_request(make_command(ctq_pkg::KIND_STOP));
    add_request(make_enqueue(64'd1, 32'd5, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0));
    quiet = 1'b1;
    for (int i = 0; i < 24; i++) add_request(make_command(ctq_pkg::KIND_DEQ));
    wait_drained();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
